### rtl/core/sfck_pkg.sv
`timescale 1ns / 1ps

package sfck_pkg;

    // coordinate and key widths
    localparam int COORD_W   = 32;
    localparam int Z_W       = 21;
    localparam int KEY_W     = 64;
    localparam int ORDER_W   = 5;
    localparam int MAX_ORDER = 16;
    localparam int HIL_W     = MAX_ORDER;
    localparam int DIST_W    = 2 * MAX_ORDER;
    localparam int CFG_W     = 5;

    // hilbert levels walked per pipeline stage, and stage count
    localparam int LVL_PER_STAGE = 4;
    localparam int HIL_STAGES    = MAX_ORDER / LVL_PER_STAGE;

    // configuration register indexes
    localparam logic CFG_CURVE_MODE = 1'b0;
    localparam logic CFG_GRID_ORDER = 1'b1;

    localparam logic [ORDER_W-1:0] GRID_ORDER_RST = 5'd8;

    typedef enum logic [1:0] {
        MODE_HILBERT = 2'd0,
        MODE_MORTON2 = 2'd1,
        MODE_MORTON3 = 2'd2
    } curve_mode_t;

    // hilbert walk state carried between stages: remaining coordinate bits
    // (msb next), quadrant transform and the digits produced so far
    typedef struct packed {
        logic [HIL_W-1:0]  hx;
        logic [HIL_W-1:0]  hy;
        logic              swp;
        logic              inv;
        logic [DIST_W-1:0] hkey;
    } hil_t;

endpackage

### rtl/core/sfck_morton.sv
`timescale 1ns / 1ps

module sfck_morton (
    input  sfck_pkg::curve_mode_t          mode,
    input  logic [sfck_pkg::COORD_W-1:0]   x,
    input  logic [sfck_pkg::COORD_W-1:0]   y,
    input  logic [sfck_pkg::Z_W-1:0]       z,
    output logic [sfck_pkg::KEY_W-1:0]     key
);

    logic [sfck_pkg::KEY_W-1:0] m2;
    logic [sfck_pkg::KEY_W-1:0] m3;

    // bit interleaving is pure wiring
    always_comb begin
        m2 = '0;
        m3 = '0;
        for (int i = 0; i < sfck_pkg::COORD_W; i++) begin
            m2[2*i]   = x[i];
            m2[2*i+1] = y[i];
        end
        for (int i = 0; i < sfck_pkg::Z_W; i++) begin
            m3[3*i]   = x[i];
            m3[3*i+1] = y[i];
            m3[3*i+2] = z[i];
        end
    end

    // hilbert mode and the unused selector leave zero here
    always_comb begin
        case (mode)
            sfck_pkg::MODE_MORTON2: key = m2;
            sfck_pkg::MODE_MORTON3: key = m3;
            default:                key = '0;
        endcase
    end

endmodule

### rtl/core/sfck_hil_stage.sv
`timescale 1ns / 1ps

module sfck_hil_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  sfck_pkg::hil_t in_st,
    output logic           out_valid,
    output sfck_pkg::hil_t out_st
);

    sfck_pkg::hil_t st_next;
    sfck_pkg::hil_t st_reg;
    logic           valid_reg;

    // walk four levels, msb first; transform tracked as swap and invert flags
    always_comb begin
        logic [sfck_pkg::HIL_W-1:0]  x;
        logic [sfck_pkg::HIL_W-1:0]  y;
        logic                        swp;
        logic                        inv;
        logic [sfck_pkg::DIST_W-1:0] hkey;
        logic                        rx;
        logic                        ry;
        x    = in_st.hx;
        y    = in_st.hy;
        swp  = in_st.swp;
        inv  = in_st.inv;
        hkey = in_st.hkey;
        for (int j = 0; j < sfck_pkg::LVL_PER_STAGE; j++) begin
            rx   = inv ^ (swp ? y[sfck_pkg::HIL_W-1] : x[sfck_pkg::HIL_W-1]);
            ry   = inv ^ (swp ? x[sfck_pkg::HIL_W-1] : y[sfck_pkg::HIL_W-1]);
            hkey = {hkey[sfck_pkg::DIST_W-3:0], rx, rx ^ ry};
            if (!ry) begin
                inv = inv ^ rx;
                swp = ~swp;
            end
            x = {x[sfck_pkg::HIL_W-2:0], 1'b0};
            y = {y[sfck_pkg::HIL_W-2:0], 1'b0};
        end
        st_next.hx   = x;
        st_next.hy   = y;
        st_next.swp  = swp;
        st_next.inv  = inv;
        st_next.hkey = hkey;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

### rtl/core/space_filling_curve_key_core.sv
`timescale 1ns / 1ps

// space-filling-curve key core
// input channel s_*: one item of grid coordinates (x, y, z) per handshake
// output channel m_*: one 64-bit key per item, in input order
// cfg port: cfg_wr_en writes cfg_wr_data into register cfg_index
//   index 0 curve_mode (0 hilbert 2d, 1 morton 2d, 2 morton 3d, 3 key zero)
//   index 1 grid_order (hilbert grid side 2^order, above 16 taken as 16)
// write config only while no item is in flight
// path: entry register, four walk stages, output register
// throughput: one item per cycle unless stalled; the hilbert walk takes
//   four levels per stage over four stages, which sets the pipeline depth
// reset: pipeline emptied, curve_mode 0, grid_order 8
// stall: whole pipeline holds while the output item waits, s_ready follows;
//   the pipeline moves as one whenever the output register is empty or
//   being taken, so bubbles travel along rather than being squeezed out
module space_filling_curve_key_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sfck_pkg::COORD_W-1:0]        s_coord_x,
    input  logic [sfck_pkg::COORD_W-1:0]        s_coord_y,
    input  logic [sfck_pkg::Z_W-1:0]            s_coord_z,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sfck_pkg::KEY_W-1:0]          m_curve_key,

    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [sfck_pkg::CFG_W-1:0]          cfg_wr_data
);

    localparam int NS = sfck_pkg::HIL_STAGES;

    // config registers
    sfck_pkg::curve_mode_t             curve_mode_reg;
    logic [sfck_pkg::ORDER_W-1:0]      grid_order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_mode_reg <= sfck_pkg::MODE_HILBERT;
            grid_order_reg <= sfck_pkg::GRID_ORDER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfck_pkg::CFG_CURVE_MODE:
                    curve_mode_reg <= sfck_pkg::curve_mode_t'(cfg_wr_data[1:0]);
                sfck_pkg::CFG_GRID_ORDER:
                    grid_order_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline moves unless a finished key is stuck at the output
    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // entry stage: mask to grid, seed the walk, build the morton code
    logic [sfck_pkg::ORDER_W-1:0] order_sat;
    logic [sfck_pkg::HIL_W-1:0]   grid_mask;
    sfck_pkg::hil_t               hil_seed;
    logic [sfck_pkg::KEY_W-1:0]   morton_key;

    assign order_sat = (grid_order_reg > sfck_pkg::ORDER_W'(sfck_pkg::MAX_ORDER))
                     ? sfck_pkg::ORDER_W'(sfck_pkg::MAX_ORDER) : grid_order_reg;
    assign grid_mask = ~({sfck_pkg::HIL_W{1'b1}} << order_sat);

    // the walk always starts at the top bit; leading zero levels only
    // toggle the swap flag, so start with swap set for an odd order
    always_comb begin
        hil_seed.hx   = s_coord_x[sfck_pkg::HIL_W-1:0] & grid_mask;
        hil_seed.hy   = s_coord_y[sfck_pkg::HIL_W-1:0] & grid_mask;
        hil_seed.swp  = order_sat[0];
        hil_seed.inv  = 1'b0;
        hil_seed.hkey = '0;
    end

    sfck_morton u_morton (
        .mode (curve_mode_reg),
        .x    (s_coord_x),
        .y    (s_coord_y),
        .z    (s_coord_z),
        .key  (morton_key)
    );

    // stage registers: index 0 is the entry stage, then one per walk stage
    logic                       vld [0:NS];
    sfck_pkg::hil_t             hil [0:NS];
    logic                       entry_valid_reg;
    sfck_pkg::hil_t             entry_hil_reg;
    logic [sfck_pkg::KEY_W-1:0] morton_reg [0:NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (adv) begin
            entry_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            entry_hil_reg <= hil_seed;
            morton_reg[0] <= morton_key;
            for (int i = 1; i <= NS; i++) begin
                morton_reg[i] <= morton_reg[i-1];
            end
        end
    end

    assign vld[0] = entry_valid_reg;
    assign hil[0] = entry_hil_reg;

    // hilbert walk, four levels per stage
    for (genvar g = 0; g < NS; g++) begin : g_walk
        sfck_hil_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (vld[g]),
            .in_st     (hil[g]),
            .out_valid (vld[g+1]),
            .out_st    (hil[g+1])
        );
    end

    // output register: pick the curve
    logic [sfck_pkg::KEY_W-1:0] key_next;
    logic [sfck_pkg::KEY_W-1:0] key_reg;

    always_comb begin
        case (curve_mode_reg)
            sfck_pkg::MODE_HILBERT:
                key_next = {{(sfck_pkg::KEY_W - sfck_pkg::DIST_W){1'b0}}, hil[NS].hkey};
            default:
                key_next = morton_reg[NS];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= key_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_curve_key = key_reg;

endmodule

### sim/curve_key_checker.sv
`timescale 1ns / 1ps

module curve_key_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [sfck_pkg::COORD_W-1:0]  s_coord_x,
    input  logic [sfck_pkg::COORD_W-1:0]  s_coord_y,
    input  logic [sfck_pkg::Z_W-1:0]      s_coord_z,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [sfck_pkg::KEY_W-1:0]    m_curve_key,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [sfck_pkg::CFG_W-1:0]    cfg_wr_data,
    output int                            keys_in_flight,
    output int                            key_errors
);
    import sfck_pkg::*;

    logic [1:0]         mode_reg  = MODE_HILBERT;
    logic [ORDER_W-1:0] order_reg = GRID_ORDER_RST;
    logic [KEY_W-1:0]   pending_keys[$];
    int                 in_flight = 0;
    int                 errors    = 0;

    assign keys_in_flight = in_flight;
    assign key_errors     = errors;

    // xy-to-d walk, coordinates masked to the grid, order capped at 16
    function automatic logic [KEY_W-1:0] hilbert_distance(logic [31:0] x, logic [31:0] y,
                                                         logic [ORDER_W-1:0] ord_in);
        int unsigned      ord;
        logic [31:0]      side;
        logic [31:0]      top;
        logic [31:0]      s;
        logic [31:0]      t;
        logic             rx;
        logic             ry;
        logic [KEY_W-1:0] d;
        ord  = (ord_in > MAX_ORDER) ? MAX_ORDER : ord_in;
        side = 32'd1 << ord;
        top  = side - 32'd1;
        x    = x & top;
        y    = y & top;
        d    = '0;
        for (s = side >> 1; s != 0; s = s >> 1) begin
            rx = |(x & s);
            ry = |(y & s);
            // quadrant digit is (3 * rx) xor ry
            d = d + {32'd0, s} * {32'd0, s} * {62'd0, rx, rx ^ ry};
            if (!ry) begin
                if (rx) begin
                    x = top - x;
                    y = top - y;
                end
                t = x;
                x = y;
                y = t;
            end
        end
        return d;
    endfunction

    function automatic logic [KEY_W-1:0] morton2_key(logic [31:0] x, logic [31:0] y);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < 32; i++) begin
            k[2*i]   = x[i];
            k[2*i+1] = y[i];
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] morton3_key(logic [31:0] x, logic [31:0] y,
                                                    logic [Z_W-1:0] z);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < Z_W; i++) begin
            k[3*i]   = x[i];
            k[3*i+1] = y[i];
            k[3*i+2] = z[i];
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] predict_curve_key(logic [31:0] x, logic [31:0] y,
                                                          logic [Z_W-1:0] z);
        case (mode_reg)
            MODE_HILBERT: return hilbert_distance(x, y, order_reg);
            MODE_MORTON2: return morton2_key(x, y);
            MODE_MORTON3: return morton3_key(x, y, z);
            default:      return '0;
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        logic [KEY_W-1:0] want;
        if (!aresetn) begin
            mode_reg  = MODE_HILBERT;
            order_reg = GRID_ORDER_RST;
            pending_keys.delete();
        end else begin
            // retire before accepting so a key never matches its own item
            if (m_valid && m_ready) begin
                if (pending_keys.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected curve_key, expected none, actual %h",
                             $time, m_curve_key);
                end else begin
                    want = pending_keys.pop_front();
                    if (m_curve_key !== want) begin
                        errors++;
                        $display("%0t: curve_key mismatch, expected %h, actual %h",
                                 $time, want, m_curve_key);
                    end
                end
            end
            if (s_valid && s_ready)
                pending_keys = {pending_keys,
                                predict_curve_key(s_coord_x, s_coord_y, s_coord_z)};
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CURVE_MODE: mode_reg  = cfg_wr_data[1:0];
                    CFG_GRID_ORDER: order_reg = cfg_wr_data[ORDER_W-1:0];
                    default: ;
                endcase
            end
        end
        in_flight <= pending_keys.size();
    end

endmodule

### sim/tb_space_filling_curve_key_core.sv
`timescale 1ns / 1ps

module tb_space_filling_curve_key_core;
    import sfck_pkg::*;

    // unused selector value, the block answers with a zero key
    localparam logic [1:0] MODE_KEY_ZERO = 2'd3;

    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES  = 80;     // receiver hold-off, well past pipeline depth
    localparam int DRAIN_CYCLES = 10;     // extra idle time after the final drain
    localparam int CYCLE_LIMIT  = 200000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [COORD_W-1:0]  s_coord_x;
    logic [COORD_W-1:0]  s_coord_y;
    logic [Z_W-1:0]      s_coord_z;
    logic                m_valid;
    logic                m_ready;
    logic [KEY_W-1:0]    m_curve_key;
    logic                cfg_wr_en;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_wr_data;

    int                  keys_in_flight;
    int                  key_errors;
    int                  cycle_count     = 0;
    int                  holds_requested = 0;
    int                  holds_served    = 0;
    bit                  tx_idle_en      = 1'b1;
    bit                  rx_idle_en      = 1'b1;

    always #5 aclk = ~aclk;

    space_filling_curve_key_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_curve_key (m_curve_key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // watches both channels and the config port, predicts every key
    curve_key_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .s_coord_z      (s_coord_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_curve_key    (m_curve_key),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .keys_in_flight (keys_in_flight),
        .key_errors     (key_errors)
    );

    // watchdog, far above the slowest legal run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    // so the pipeline fills up and s_ready drops
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != holds_requested) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end
            m_ready <= rx_idle_en ? ($urandom_range(99) >= 28) : 1'b1;
        end
    end

    // mix of corner values and fully random words so every bit toggles
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(65535);
            3:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [Z_W-1:0] rand_z();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return r[Z_W-1:0];
        endcase
    endfunction

    // present one item and hold it until accepted; valid stays high
    // for the next item unless a gap is taken
    task automatic offer_item(input logic [31:0] x, input logic [31:0] y,
                              input logic [Z_W-1:0] z);
        if (tx_idle_en && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every key has come back; each item
    // makes exactly one key, so nothing is left in the pipe after that
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (keys_in_flight != 0);
    endtask

    // write both registers back to back; spare mode bits get random junk
    task automatic program_curve(input logic [1:0] mode, input logic [ORDER_W-1:0] order);
        logic [2:0] junk;
        junk = 3'($urandom);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_CURVE_MODE;
        cfg_wr_data <= {junk, mode};
        @(posedge aclk);
        cfg_index   <= CFG_GRID_ORDER;
        cfg_wr_data <= order;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [1:0]         mode;
        logic [ORDER_W-1:0] order;
        int                 n;
        int                 sent;
        int                 phase;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_coord_x   = '0;
        s_coord_y   = '0;
        s_coord_z   = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_CURVE_MODE;
        cfg_wr_data = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: hilbert, order 8, upper coordinate bits dropped
        offer_item(32'h0000_00FF, 32'h0000_0000, '0);
        offer_item(32'hFFFF_FF80, 32'h0000_0155, '1);

        // largest grid, corners and coordinates beyond the grid
        wait_drained();
        program_curve(MODE_HILBERT, 5'd16);
        offer_item(32'h0000_0000, 32'h0000_0000, '0);
        offer_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        offer_item(32'h0000_FFFF, 32'h0000_0000, '0);
        offer_item(32'h0000_0000, 32'h0000_FFFF, '1);
        offer_item(32'h1234_5678, 32'hABCD_0000, 21'h0A_5A5A);

        // smallest real grid, three of its four cells, one from out-of-grid coordinates
        wait_drained();
        program_curve(MODE_HILBERT, 5'd1);
        offer_item(32'd1, 32'd0, '0);
        offer_item(32'd1, 32'd1, '0);
        offer_item(32'd0, 32'd1, '0);
        offer_item(32'hFFFF_FFFE, 32'd3, '0);

        // single-cell grid gives a zero key
        wait_drained();
        program_curve(MODE_HILBERT, 5'd0);
        offer_item(32'hFFFF_FFFF, 32'h5A5A_5A5A, '1);

        // orders above 16 saturate, top of range and just past the cap
        wait_drained();
        program_curve(MODE_HILBERT, 5'd31);
        offer_item(32'hDEAD_BEEF, 32'h00C0_FFEE, '0);
        wait_drained();
        program_curve(MODE_HILBERT, 5'd17);
        offer_item(32'hABCD_EF01, 32'h10FE_DCBA, '0);

        // 2d morton, z must be ignored
        wait_drained();
        program_curve(MODE_MORTON2, 5'd8);
        offer_item(32'hFFFF_FFFF, 32'h0000_0000, '1);
        offer_item(32'h0000_0000, 32'hFFFF_FFFF, '0);
        offer_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);

        // 3d morton, each axis alone then all ones; x and y upper bits dropped
        wait_drained();
        program_curve(MODE_MORTON3, 5'd8);
        offer_item(32'hFFFF_FFFF, 32'h0000_0000, '0);
        offer_item(32'h0000_0000, 32'hFFFF_FFFF, '0);
        offer_item(32'h0000_0000, 32'h0000_0000, '1);
        offer_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);

        // unused selector
        wait_drained();
        program_curve(MODE_KEY_ZERO, 5'd8);
        offer_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);

        // random phases, each under its own setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0, 1, 2, 3: mode = MODE_HILBERT;
                4, 5:       mode = MODE_MORTON2;
                6, 7:       mode = MODE_MORTON3;
                default:    mode = ($urandom_range(1)) ? MODE_KEY_ZERO : MODE_MORTON3;
            endcase
            case ($urandom_range(5))
                0:       order = 5'd16;
                1:       order = 5'd1;
                2:       order = ORDER_W'($urandom_range(31));
                default: order = ORDER_W'($urandom_range(1, 16));
            endcase
            n = $urandom_range(15, 50);

            wait_drained();
            program_curve(mode, order);

            // long stretch with no idling on either side
            if (phase == 3) begin
                n          = 120;
                tx_idle_en = 1'b0;
                rx_idle_en <= 1'b0;
            end
            // receiver holds off while the sender keeps offering
            if (phase == 1 || phase == 5) begin
                n = 60;
                holds_requested <= holds_requested + 1;
            end

            repeat (n) offer_item(rand_coord(), rand_coord(), rand_z());
            sent = sent + n;

            if (phase == 3) begin
                tx_idle_en = 1'b1;
                rx_idle_en <= 1'b1;
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (key_errors == 0 && keys_in_flight == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### space_filling_curve_key_core.f
rtl/core/sfck_pkg.sv
rtl/core/sfck_morton.sv
rtl/core/sfck_hil_stage.sv
rtl/core/space_filling_curve_key_core.sv
sim/curve_key_checker.sv
sim/tb_space_filling_curve_key_core.sv
